/* rtl/core/tpb_pkg.sv */
// tpb_pkg: period codes and small calendar helpers for the period bucketer.
// No dependencies; imported by timestamp_period_bucketer.
`default_nettype none

package tpb_pkg;

  typedef logic [3:0] period_t;

  localparam period_t PER_MIN1  = 4'd0;
  localparam period_t PER_MIN5  = 4'd1;
  localparam period_t PER_MIN10 = 4'd2;
  localparam period_t PER_MIN15 = 4'd3;
  localparam period_t PER_MIN30 = 4'd4;
  localparam period_t PER_MIN60 = 4'd5;
  localparam period_t PER_DAY   = 4'd6;
  localparam period_t PER_WEEK  = 4'd7;
  localparam period_t PER_MONTH = 4'd8;

  localparam period_t PERIOD_RESET = PER_DAY;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [3:0]  MON_JAN  = 4'd1;
  localparam logic [3:0]  MON_FEB  = 4'd2;
  localparam logic [3:0]  MON_DEC  = 4'd12;

  // Days in month; 0 for a month code that means nothing.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Month term of the March-based day count, reduced mod 7.
  function automatic logic [2:0] dow_month_ofs(input logic [3:0] m);
    logic [2:0] ofs;
    case (m)
      4'd1:    ofs = 3'd5;
      4'd2:    ofs = 3'd1;
      4'd3:    ofs = 3'd0;
      4'd4:    ofs = 3'd3;
      4'd5:    ofs = 3'd5;
      4'd6:    ofs = 3'd1;
      4'd7:    ofs = 3'd3;
      4'd8:    ofs = 3'd6;
      4'd9:    ofs = 3'd2;
      4'd10:   ofs = 3'd4;
      4'd11:   ofs = 3'd0;
      4'd12:   ofs = 3'd2;
      default: ofs = 3'd0;
    endcase
    return ofs;
  endfunction

  // Length of a minute period; 0 for codes that are not minute periods.
  function automatic logic [6:0] period_minutes(input period_t p);
    logic [6:0] len;
    case (p)
      PER_MIN1:  len = 7'd1;
      PER_MIN5:  len = 7'd5;
      PER_MIN10: len = 7'd10;
      PER_MIN15: len = 7'd15;
      PER_MIN30: len = 7'd30;
      PER_MIN60: len = 7'd60;
      default:   len = 7'd0;
    endcase
    return len;
  endfunction

  // Minute floored to the period; codes without a minute period keep it.
  function automatic logic [5:0] floor_minute(input logic [5:0] mi, input period_t p);
    logic [9:0] prod;
    logic [3:0] q5;
    logic [2:0] q10;
    logic [5:0] fm;
    prod = 10'(mi) * 10'd13;   // mi*13/64 ~ mi/5, mi*13/128 ~ mi/10
    q5   = prod[9:6];
    q10  = prod[9:7];
    case (p)
      PER_MIN5:  fm = 6'({q5, 2'b00}) + 6'(q5);
      PER_MIN10: fm = 6'({q10, 3'b000}) + 6'({q10, 1'b0});
      PER_MIN15: fm = (mi >= 6'd45) ? 6'd45 : (mi >= 6'd30) ? 6'd30 :
                      (mi >= 6'd15) ? 6'd15 : 6'd0;
      PER_MIN30: fm = (mi >= 6'd30) ? 6'd30 : 6'd0;
      PER_MIN60: fm = 6'd0;
      default:   fm = mi;
    endcase
    return fm;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/timestamp_period_bucketer.sv */
// timestamp_period_bucketer: floors a Gregorian timestamp to its bar period
// and returns period start and end. Depends on tpb_pkg.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------
// request   | start / busy         | in_year in_month in_day in_hour in_minute
//           |                      | in_second
// result    | done (1-cycle strobe)| start_* end_* bad_date
// config    | cfg_write            | cfg_data (bar_period)
//
// Four register stages; one request per cycle, the result leaving on done from
// the last stage. Stages: input capture and /100 reciprocal, leap / validity /
// weekday sum, weekday mod 7 and end time of day, calendar carry/borrow into
// the result registers.
// busy is high only in reset. The receiver cannot stall, so nothing is held.
// Reset clears the valid bits and sets bar_period to daily.
`default_nettype none

module timestamp_period_bucketer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [13:0]          in_year,
  input  wire logic [3:0]           in_month,
  input  wire logic [4:0]           in_day,
  input  wire logic [4:0]           in_hour,
  input  wire logic [5:0]           in_minute,
  input  wire logic [5:0]           in_second,
  // configuration
  input  wire logic                 cfg_write,
  input  wire tpb_pkg::period_t     cfg_data,
  // result
  output logic                      done,
  output logic [13:0]               start_year,
  output logic [3:0]                start_month,
  output logic [4:0]                start_day,
  output logic [4:0]                start_hour,
  output logic [5:0]                start_minute,
  output logic [13:0]               end_year,
  output logic [3:0]                end_month,
  output logic [4:0]                end_day,
  output logic [4:0]                end_hour,
  output logic [5:0]                end_minute,
  output logic                      bad_date
);

  import tpb_pkg::*;

  period_t bar_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      bar_period <= cfg_data;
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: capture, year/100 by reciprocal ----------------
  logic [13:0] yp_c;
  logic [26:0] prod_y, prod_yp;

  assign yp_c    = (in_month <= MON_FEB) ? in_year - 14'd1 : in_year;  // March-based year
  assign prod_y  = 27'(in_year) * 27'd5243;   // *5243 >> 19 == /100 below 10000
  assign prod_yp = 27'(yp_c) * 27'd5243;

  logic        v1;
  logic [13:0] y1, yp1;
  logic [3:0]  m1;
  logic [4:0]  d1, h1;
  logic [5:0]  mi1, s1;
  period_t     per1;
  logic [7:0]  q100_1, q100p_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y1      <= in_year;
      yp1     <= yp_c;
      m1      <= in_month;
      d1      <= in_day;
      h1      <= in_hour;
      mi1     <= in_minute;
      s1      <= in_second;
      per1    <= bar_period;
      q100_1  <= prod_y[26:19];
      q100p_1 <= prod_yp[26:19];
    end
  end

  // ---------------- stage 2: leap year, validity, weekday sum ----------------
  logic [14:0] y100_c;
  logic        div100_c, leap_c, bad_c;
  logic [4:0]  mlen_c, pml_c;
  logic [3:0]  prev_m_c;
  logic [14:0] sum_c;
  logic [5:0]  fm_c;

  assign y100_c   = 15'(q100_1) * 15'd100;
  assign div100_c = (15'(y1) == y100_c);
  assign leap_c   = div100_c ? (q100_1[1:0] == 2'd0) : (y1[1:0] == 2'd0);
  assign mlen_c   = month_len(m1, leap_c);
  assign prev_m_c = (m1 == MON_JAN) ? MON_DEC : m1 - 4'd1;
  assign pml_c    = month_len(prev_m_c, leap_c);

  assign bad_c = (y1 == 14'd0) || (y1 > YEAR_MAX) || (m1 == 4'd0) || (m1 > MON_DEC) ||
                 (d1 == 5'd0) || (d1 > mlen_c) || (h1 > 5'd23) || (mi1 > 6'd59) ||
                 (s1 > 6'd59);

  // day count mod 7: 365*y == y, plus the constant that makes Monday read 1
  assign sum_c = 15'(yp1) + 15'(yp1[13:2]) - 15'(q100p_1) + 15'(q100p_1[7:2]) +
                 15'(dow_month_ofs(m1)) + 15'(d1) + 15'd1;

  assign fm_c = floor_minute(mi1, per1);

  logic        v2, bad2;
  logic [13:0] y2;
  logic [3:0]  m2;
  logic [4:0]  d2, h2, mlen2, pml2;
  logic [5:0]  fm2;
  period_t     per2;
  logic [14:0] sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      bad2  <= bad_c;
      y2    <= y1;
      m2    <= m1;
      d2    <= d1;
      h2    <= h1;
      mlen2 <= mlen_c;
      pml2  <= pml_c;
      fm2   <= fm_c;
      per2  <= per1;
      sum2  <= sum_c;
    end
  end

  // ---------------- stage 3: weekday, end time of day ----------------
  logic [28:0] prod7_c;
  logic [12:0] q7_c;
  logic [14:0] r15_c;
  logic [3:0]  r_c, rfix_c;
  logic [2:0]  dow_c;

  assign prod7_c = 29'(sum2) * 29'd9362;   // underestimates /7 by at most one
  assign q7_c    = prod7_c[28:16];
  assign r15_c   = sum2 - (15'(q7_c) * 15'd7);
  assign r_c     = r15_c[3:0];
  assign rfix_c  = (r_c >= 4'd7) ? r_c - 4'd7 : r_c;
  assign dow_c   = 3'(rfix_c) + 3'd1;      // Monday 1 .. Sunday 7

  logic [6:0] em_raw_c;
  logic       hcarry_c, dcarry_c;
  logic [5:0] em_c;
  logic [4:0] eh_raw_c, eh_c;

  assign em_raw_c = 7'(fm2) + period_minutes(per2);
  assign hcarry_c = (em_raw_c >= 7'd60);
  assign em_c     = hcarry_c ? 6'd0 : em_raw_c[5:0];
  assign eh_raw_c = h2 + 5'(hcarry_c);
  assign dcarry_c = (eh_raw_c == 5'd24);
  assign eh_c     = dcarry_c ? 5'd0 : eh_raw_c;

  logic        v3, bad3, dc3;
  logic [13:0] y3;
  logic [3:0]  m3;
  logic [4:0]  d3, h3, mlen3, pml3, eh3;
  logic [5:0]  fm3, em3;
  logic [2:0]  dow3;
  period_t     per3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      bad3  <= bad2;
      y3    <= y2;
      m3    <= m2;
      d3    <= d2;
      h3    <= h2;
      mlen3 <= mlen2;
      pml3  <= pml2;
      fm3   <= fm2;
      per3  <= per2;
      dow3  <= dow_c;
      em3   <= em_c;
      eh3   <= eh_c;
      dc3   <= dcarry_c;
    end
  end

  // ---------------- stage 4: calendar carry and borrow ----------------
  // End date = input date + k days, with at most one month carry.
  // Month end is the day after the last of the month.
  logic [5:0]  k_c, e_c;
  logic        ecarry_c, esat_c, minute_per_c;
  logic [13:0] ey_c, sy_c;
  logic [3:0]  emo_c, smo_c;
  logic [4:0]  ed_c, sd_c, eh4_c, sh_c;
  logic [5:0]  emi_c, smi_c;
  logic [5:0]  borrow_day_c;

  always_comb begin
    minute_per_c = (per3 inside {[PER_MIN1:PER_MIN60]});
    case (per3)
      PER_DAY:   k_c = 6'd1;
      PER_WEEK:  k_c = 6'd7 - 6'(dow3);
      PER_MONTH: k_c = 6'(mlen3) + 6'd1 - 6'(d3);
      default:   k_c = minute_per_c ? 6'(dc3) : 6'd0;
    endcase

    e_c      = 6'(d3) + k_c;
    ecarry_c = (e_c > 6'(mlen3));
    ed_c     = ecarry_c ? 5'(e_c - 6'(mlen3)) : 5'(e_c);
    ey_c     = y3;
    emo_c    = m3;
    if (ecarry_c) begin
      if (m3 == MON_DEC) begin
        emo_c = MON_JAN;
        ey_c  = y3 + 14'd1;
      end else begin
        emo_c = m3 + 4'd1;
      end
    end
    esat_c = ecarry_c && (m3 == MON_DEC) && (y3 == YEAR_MAX);

    if (minute_per_c) begin
      eh4_c = eh3;
      emi_c = em3;
    end else if (per3 == PER_DAY || per3 == PER_WEEK || per3 == PER_MONTH) begin
      eh4_c = 5'd0;
      emi_c = 6'd0;
    end else begin
      eh4_c = h3;
      emi_c = fm3;
    end

    if (esat_c) begin
      ey_c  = YEAR_MAX;
      emo_c = MON_DEC;
      ed_c  = 5'd31;
      eh4_c = 5'd23;
      emi_c = 6'd59;
    end

    // start
    borrow_day_c = 6'(pml3) + 6'(d3) - 6'(dow3);
    sy_c  = y3;
    smo_c = m3;
    sd_c  = d3;
    sh_c  = h3;
    smi_c = fm3;
    case (per3)
      PER_DAY: begin
        sh_c  = 5'd0;
        smi_c = 6'd0;
      end
      PER_WEEK: begin
        sh_c  = 5'd0;
        smi_c = 6'd0;
        if (d3 > 5'(dow3)) begin
          sd_c = d3 - 5'(dow3);
        end else if (m3 == MON_JAN) begin
          if (y3 == 14'd1) begin
            // before year 1: clamp to the first day of the calendar
            sd_c = 5'd1;
          end else begin
            sy_c  = y3 - 14'd1;
            smo_c = MON_DEC;
            sd_c  = borrow_day_c[4:0];
          end
        end else begin
          smo_c = m3 - 4'd1;
          sd_c  = borrow_day_c[4:0];
        end
      end
      PER_MONTH: begin
        sd_c  = 5'd1;
        sh_c  = 5'd0;
        smi_c = 6'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      bad_date <= bad3;
      if (bad3) begin
        start_year   <= 14'd0;
        start_month  <= 4'd0;
        start_day    <= 5'd0;
        start_hour   <= 5'd0;
        start_minute <= 6'd0;
        end_year     <= 14'd0;
        end_month    <= 4'd0;
        end_day      <= 5'd0;
        end_hour     <= 5'd0;
        end_minute   <= 6'd0;
      end else begin
        start_year   <= sy_c;
        start_month  <= smo_c;
        start_day    <= sd_c;
        start_hour   <= sh_c;
        start_minute <= smi_c;
        end_year     <= ey_c;
        end_month    <= emo_c;
        end_day      <= ed_c;
        end_hour     <= eh4_c;
        end_minute   <= emi_c;
      end
    end
  end

  // ---------------- assertions ----------------
  a_request_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("request did not produce a result four cycles later");

  a_stage_to_done: assert property (@(posedge clk) disable iff (rst)
    v3 |=> done)
    else $error("last stage valid did not produce done");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_date) |-> (start_year == 14'd0 && end_year == 14'd0 &&
                            start_day == 5'd0 && end_day == 5'd0))
    else $error("bad date result carries nonzero fields");

  a_good_month: assert property (@(posedge clk) disable iff (rst)
    (done && !bad_date) |-> (start_month >= MON_JAN && start_month <= MON_DEC &&
                             end_month >= MON_JAN && end_month <= MON_DEC &&
                             start_day != 5'd0 && end_day != 5'd0))
    else $error("valid result has month or day out of range");

endmodule

`default_nettype wire
